[hdl/streaming_k_extreme_tracker_assert.svh]
// Assertion helpers shared by the tracker modules.
`ifndef STREAMING_K_EXTREME_TRACKER_ASSERT_SVH
`define STREAMING_K_EXTREME_TRACKER_ASSERT_SVH

// Property checked on every clock edge outside reset.
`define SKXT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Implication checked in the cycle after the trigger.
`define SKXT_ASSERT_NEXT(lbl, trig, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |=> (cons)) \
        else $error(msg);

`endif

[hdl/skxt_pkg.sv]
package skxt_pkg;

    localparam int SAMPLE_W     = 32;
    localparam int RANK_W       = 4;
    localparam int KEEP_W       = 5;
    localparam int S_TDATA_W    = 32;
    localparam int M_TDATA_W    = 40;
    localparam int PAD_W        = M_TDATA_W - SAMPLE_W - RANK_W;
    localparam int MAX_KEEP_DEF = 16;
    localparam int CFG_ADDR_W   = 1;

    localparam logic [KEEP_W-1:0] KEEP_RESET = 5'd1;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_KEEP_COUNT = 1'b0,
        REG_ORDER_MODE = 1'b1
    } skxt_reg_t;

    typedef logic signed [SAMPLE_W-1:0] skxt_val_t;

    typedef struct packed {
        logic ins_en;
        logic shift_down;
    } skxt_ctl_t;

    typedef struct packed {
        logic valid;
        logic last;
        logic free;
    } skxt_stat_t;

endpackage

[hdl/streaming_k_extreme_tracker.sv]
// Streaming k-extreme tracker: one sample accepted per cycle while s_tready is high.
// A run appears on the master side in the cycle after its set_end sample is accepted.
// Throughput: a run of n results drains at one per cycle while m_tready is high;
// a set_end sample stalls only while the previous run is still draining.
// Reset (aresetn low, synchronous): held count and pending results clear,
// keep_count returns to 1, order_mode to 0; stored values are not cleared.
module streaming_k_extreme_tracker
    import skxt_pkg::*;
#(
    parameter int MAX_KEEP = MAX_KEEP_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [31:0] sample
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // [31:0] kept_value, [35:32] rank, [39:36] zero
    output logic                  m_tlast,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [KEEP_W-1:0]     cfg_wdata
);

    localparam int CW = $clog2(MAX_KEEP + 1);
    localparam int EW = (KEEP_W > CW) ? KEEP_W : CW;

    logic [KEEP_W-1:0] keep_count_reg;
    logic              order_mode_reg;
    logic [EW-1:0]     kc_ext;
    logic [CW-1:0]     k_eff;
    logic [CW-1:0]     fill;
    logic              s_accept;
    logic              pop;
    skxt_val_t         s_sample;
    skxt_val_t         new_val [MAX_KEEP];
    skxt_val_t         head_val;
    logic [RANK_W-1:0] head_rank;
    skxt_stat_t        stat;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            keep_count_reg <= KEEP_RESET;
            order_mode_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            case (skxt_reg_t'(cfg_addr))
                REG_KEEP_COUNT: keep_count_reg <= cfg_wdata;
                REG_ORDER_MODE: order_mode_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign kc_ext = EW'(keep_count_reg);

    always_comb begin
        if (kc_ext == '0) begin
            k_eff = CW'(1);
        end else if (kc_ext > EW'(MAX_KEEP)) begin
            k_eff = CW'(MAX_KEEP);
        end else begin
            k_eff = CW'(kc_ext);
        end
    end

    // hold a set_end request until the previous run has drained
    assign s_tready = !s_tlast || stat.free;
    assign s_accept = s_tvalid && s_tready;
    assign s_sample = s_tdata;

    assign pop = stat.valid && m_tready;

    skxt_store #(
        .MAX_KEEP (MAX_KEEP),
        .CW       (CW)
    ) u_store (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (s_accept),
        .sample     (s_sample),
        .set_end    (s_tlast),
        .k_eff      (k_eff),
        .order_mode (order_mode_reg),
        .new_val    (new_val),
        .fill       (fill)
    );

    skxt_out_buf #(
        .MAX_KEEP (MAX_KEEP),
        .CW       (CW)
    ) u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (s_accept && s_tlast),
        .ld_val    (new_val),
        .ld_cnt    (fill),
        .pop       (pop),
        .head_val  (head_val),
        .head_rank (head_rank),
        .stat      (stat)
    );

    assign m_tvalid = stat.valid;
    assign m_tlast  = stat.last;
    assign m_tdata  = {{PAD_W{1'b0}}, head_rank, head_val};

endmodule

[hdl/skxt_cell.sv]
module skxt_cell
    import skxt_pkg::*;
#(
    parameter int IDX = 0,
    parameter int CW  = 5
) (
    input  logic           aclk,
    input  skxt_ctl_t      ctl,
    input  skxt_val_t      sample,
    input  logic [CW-1:0]  held,
    input  logic [CW-1:0]  fill,
    input  skxt_val_t      p_self,
    input  skxt_val_t      p_lo,
    input  skxt_val_t      p_hi,
    input  logic           lo_gt,
    input  logic           hi_lt,
    output logic           gt,
    output logic           lt,
    output skxt_val_t      new_val,
    output skxt_val_t      cur_val
);

    localparam logic [CW-1:0] IDX_C   = CW'(IDX);
    localparam logic [CW-1:0] IDX_NXT = CW'(IDX + 1);

    skxt_val_t val_reg;
    skxt_val_t val_next;
    skxt_val_t up_val;
    skxt_val_t dn_val;

    assign gt = p_self > sample;
    assign lt = p_self < sample;

    // shift up: larger values move one rank higher, sample fills the gap
    assign up_val = lo_gt ? p_lo : (((held == IDX_C) || gt) ? sample : p_self);
    // shift down: smaller values move one rank lower, lowest drops out
    assign dn_val = (hi_lt && (IDX_NXT < held)) ? p_hi : (lt ? sample : p_self);

    assign new_val = ctl.shift_down ? dn_val : up_val;
    assign val_next = (ctl.ins_en && (IDX_C < fill)) ? new_val : val_reg;
    assign cur_val = val_reg;

    always_ff @(posedge aclk) begin
        val_reg <= val_next;
    end

endmodule

[hdl/skxt_store.sv]
`include "streaming_k_extreme_tracker_assert.svh"
module skxt_store
    import skxt_pkg::*;
#(
    parameter int MAX_KEEP = MAX_KEEP_DEF,
    parameter int CW       = $clog2(MAX_KEEP + 1)
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          accept,
    input  skxt_val_t     sample,
    input  logic          set_end,
    input  logic [CW-1:0] k_eff,
    input  logic          order_mode,
    output skxt_val_t     new_val [MAX_KEEP],
    output logic [CW-1:0] fill
);

    logic [CW-1:0] held_count_reg;
    logic [CW-1:0] held_count_next;
    logic [CW-1:0] held;
    logic [CW-1:0] drop_n;
    logic          over;
    logic          grow;
    skxt_ctl_t     ctl;

    skxt_val_t cur_val [MAX_KEEP];
    skxt_val_t stg     [CW+1][MAX_KEEP];
    logic      gt_w    [MAX_KEEP];
    logic      lt_w    [MAX_KEEP];

    assign over   = held_count_reg > k_eff;
    assign held   = over ? k_eff : held_count_reg;
    assign drop_n = (over && order_mode) ? (held_count_reg - k_eff) : '0;
    assign grow   = held < k_eff;
    assign fill   = grow ? (held + CW'(1)) : held;

    assign ctl.ins_en     = accept;
    assign ctl.shift_down = order_mode && !grow;

    assign held_count_next = set_end ? '0 : fill;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_count_reg <= '0;
        end else if (accept) begin
            held_count_reg <= held_count_next;
        end
    end

    // drop the lowest excess entries: shift toward rank zero
    for (genvar i = 0; i < MAX_KEEP; i++) begin : g_stg0
        assign stg[0][i] = cur_val[i];
    end
    for (genvar j = 0; j < CW; j++) begin : g_shift
        for (genvar i = 0; i < MAX_KEEP; i++) begin : g_lane
            if (i + (2 ** j) < MAX_KEEP) begin : g_mv
                assign stg[j+1][i] = drop_n[j] ? stg[j][i + (2 ** j)] : stg[j][i];
            end else begin : g_hold
                assign stg[j+1][i] = stg[j][i];
            end
        end
    end

    for (genvar i = 0; i < MAX_KEEP; i++) begin : g_cell
        skxt_val_t p_lo;
        skxt_val_t p_hi;
        logic      lo_gt;
        logic      hi_lt;

        if (i > 0) begin : g_lo
            assign p_lo  = stg[CW][i-1];
            assign lo_gt = gt_w[i-1];
        end else begin : g_lo_end
            assign p_lo  = stg[CW][i];
            assign lo_gt = 1'b0;
        end
        if (i < MAX_KEEP - 1) begin : g_hi
            assign p_hi  = stg[CW][i+1];
            assign hi_lt = lt_w[i+1];
        end else begin : g_hi_end
            assign p_hi  = stg[CW][i];
            assign hi_lt = 1'b0;
        end

        skxt_cell #(
            .IDX (i),
            .CW  (CW)
        ) u_cell (
            .aclk    (aclk),
            .ctl     (ctl),
            .sample  (sample),
            .held    (held),
            .fill    (fill),
            .p_self  (stg[CW][i]),
            .p_lo    (p_lo),
            .p_hi    (p_hi),
            .lo_gt   (lo_gt),
            .hi_lt   (hi_lt),
            .gt      (gt_w[i]),
            .lt      (lt_w[i]),
            .new_val (new_val[i]),
            .cur_val (cur_val[i])
        );
    end

    `SKXT_ASSERT(a_held_bound, held_count_reg <= CW'(MAX_KEEP), "held count above capacity")
    `SKXT_ASSERT_NEXT(a_end_clears, accept && set_end, held_count_reg == '0, "store not emptied")
    `SKXT_ASSERT_NEXT(a_fill_nonzero, accept && !set_end, held_count_reg != '0, "store lost sample")

endmodule

[hdl/skxt_out_buf.sv]
`include "streaming_k_extreme_tracker_assert.svh"
module skxt_out_buf
    import skxt_pkg::*;
#(
    parameter int MAX_KEEP = MAX_KEEP_DEF,
    parameter int CW       = $clog2(MAX_KEEP + 1)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  skxt_val_t         ld_val [MAX_KEEP],
    input  logic [CW-1:0]     ld_cnt,
    input  logic              pop,
    output skxt_val_t         head_val,
    output logic [RANK_W-1:0] head_rank,
    output skxt_stat_t        stat
);

    skxt_val_t             val_reg [MAX_KEEP];
    logic [MAX_KEEP-1:0]   vld_reg;
    logic [MAX_KEEP-1:0]   vld_next;
    logic [MAX_KEEP-1:0]   vld_load;
    logic [MAX_KEEP-1:0]   vld_sh;
    logic [RANK_W-1:0]     rank_reg;
    logic [RANK_W-1:0]     rank_next;

    for (genvar i = 0; i < MAX_KEEP; i++) begin : g_vld
        assign vld_load[i] = CW'(i) < ld_cnt;
    end

    assign vld_sh = vld_reg >> 1;

    always_comb begin
        vld_next  = vld_reg;
        rank_next = rank_reg;
        if (load) begin
            vld_next  = vld_load;
            rank_next = '0;
        end else if (pop) begin
            vld_next  = vld_sh;
            rank_next = rank_reg + RANK_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg  <= '0;
            rank_reg <= '0;
        end else begin
            vld_reg  <= vld_next;
            rank_reg <= rank_next;
        end
    end

    for (genvar i = 0; i < MAX_KEEP; i++) begin : g_val
        if (i + 1 < MAX_KEEP) begin : g_mid
            always_ff @(posedge aclk) begin
                if (load) begin
                    val_reg[i] <= ld_val[i];
                end else if (pop) begin
                    val_reg[i] <= val_reg[i+1];
                end
            end
        end else begin : g_top
            always_ff @(posedge aclk) begin
                if (load) begin
                    val_reg[i] <= ld_val[i];
                end
            end
        end
    end

    assign head_val   = val_reg[0];
    assign head_rank  = rank_reg;
    assign stat.valid = vld_reg[0];
    assign stat.last  = !vld_sh[0];
    assign stat.free  = !vld_reg[0] || (pop && !vld_sh[0]);

    `SKXT_ASSERT(a_load_free, load |-> stat.free, "run loaded over pending results")
    `SKXT_ASSERT(a_vld_packed, (vld_sh & ~vld_reg) == '0, "gap in pending results")
    `SKXT_ASSERT_NEXT(a_rank_step, pop && !load, rank_reg == RANK_W'($past(rank_reg) + 1'b1),
        "rank did not advance")

endmodule
